FILE: hdl/radix_integer_text_parser_defines.svh
// ----------------------------------------------------------------------------
// radix integer text parser assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef RADIX_INTEGER_TEXT_PARSER_DEFINES_SVH
`define RADIX_INTEGER_TEXT_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

`define RTP_ASSERT_NOW(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`define RTP_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define RTP_ASSERT_NOW(name, clk, rst_n, pre, post, msg)

`define RTP_ASSERT_NEXT(name, clk, rst_n, pre, post, msg)

`endif

`endif

FILE: hdl/rtp_pkg.sv
// ----------------------------------------------------------------------------
// rtp_pkg
// widths, character codes and digit decode for the radix integer text parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtp_pkg;

    localparam int CHAR_W          = 8;
    localparam int RADIX_W         = 6;
    localparam int DIGIT_W         = 7;
    localparam int RESULT_W        = 64;
    localparam int VALUE_WIDTH_DEF = 64;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_MIN    = 6'd2;
    localparam logic [RADIX_W-1:0] BASE_MAX    = 6'd36;

    localparam logic [DIGIT_W-1:0] NOT_DIGIT    = 7'd99;
    localparam logic [DIGIT_W-1:0] LETTER_FIRST = 7'd10;

    localparam logic [CHAR_W-1:0] SPACE_MAX  = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_APOS  = 8'h27;
    localparam logic [CHAR_W-1:0] CHAR_QUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CHAR_UNDER = 8'h5F;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LZ    = 8'h7A;

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            d = DIGIT_W'(c - CHAR_0);
        end
        else if (c >= CHAR_UA && c <= CHAR_UZ)
        begin
            d = DIGIT_W'(c - CHAR_UA) + LETTER_FIRST;
        end
        else if (c >= CHAR_LA && c <= CHAR_LZ)
        begin
            d = DIGIT_W'(c - CHAR_LA) + LETTER_FIRST;
        end
        else
        begin
            d = NOT_DIGIT;
        end
        return d;
    endfunction

endpackage

FILE: hdl/rtp_text_if.sv
// ----------------------------------------------------------------------------
// rtp_text_if
// text byte request channel with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rtp_text_if;
    logic                        valid;
    logic                        ready;
    logic [rtp_pkg::CHAR_W-1:0]  char_byte;
    logic                        has_byte;
    logic                        last;

    modport source (output valid, output char_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input char_byte, input has_byte, input last,
                    output ready);
endinterface

FILE: hdl/rtp_result_if.sv
// ----------------------------------------------------------------------------
// rtp_result_if
// parse result request channel with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rtp_result_if;
    logic                                valid;
    logic                                ready;
    logic                                ok;
    logic signed [rtp_pkg::RESULT_W-1:0] value;

    modport source (output valid, output ok, output value, input ready);
    modport sink   (input valid, input ok, input value, output ready);
endinterface

FILE: hdl/radix_integer_text_parser.sv
// ----------------------------------------------------------------------------
// radix_integer_text_parser
// streaming signed integer parser, base 2 to 36, at most one text byte per request
// ----------------------------------------------------------------------------
//  channel   role    payload
//  text      sink    char_byte[7:0], has_byte, last
//  result    source  ok, value[63:0] signed
//  cfg       write   cfg_we, cfg_wdata[5:0] (radix)
//
//  one request per cycle while no closing request is held back by a result;
//  a closing request passes from the input register to the result register
//  per-byte work is one multiply-add of the accumulator by the radix
//  between the input register and the result register
//  rst_n clears the parse state and sets radix to 10
//  a held result stalls only a closing request; other bytes keep flowing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "radix_integer_text_parser_defines.svh"

module radix_integer_text_parser #(
    parameter int VALUE_WIDTH = rtp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rtp_pkg::RADIX_W-1:0] cfg_wdata,
    rtp_text_if.sink                    text,
    rtp_result_if.source                result
);

    typedef enum logic [3:0] {
        PH_LEAD   = 4'b0001,
        PH_DIGITS = 4'b0010,
        PH_TRAIL  = 4'b0100,
        PH_FAIL   = 4'b1000
    } phase_t;

    logic [rtp_pkg::RADIX_W-1:0] radix_reg;

    logic                        s1_valid_reg;
    logic [rtp_pkg::CHAR_W-1:0]  s1_char_reg;
    logic                        s1_has_reg;
    logic                        s1_last_reg;

    phase_t                      phase_reg, phase_next;
    logic                        negative_reg, negative_next;
    logic                        seen_reg, seen_next;
    logic [VALUE_WIDTH-1:0]      acc_reg, acc_next;

    logic                        out_valid_reg, out_valid_next;
    logic                        out_ok_reg, out_ok_next;
    logic signed [rtp_pkg::RESULT_W-1:0] out_value_reg, out_value_next;

    logic                        out_free;
    logic                        s1_fire;
    logic                        text_take;

    logic [rtp_pkg::DIGIT_W-1:0] digit;
    logic                        is_sep;
    logic                        is_space;
    logic                        digit_hit;
    logic [VALUE_WIDTH-1:0]      mac;
    phase_t                      dp_phase;

    phase_t                      upd_phase;
    logic                        upd_negative;
    logic                        upd_seen;
    logic [VALUE_WIDTH-1:0]      upd_acc;

    logic                        radix_ok;
    logic                        good;
    logic [VALUE_WIDTH-1:0]      mag;
    logic signed [VALUE_WIDTH-1:0] wrapped;

    assign out_free  = !out_valid_reg || result.ready;
    assign s1_fire   = s1_valid_reg && (!s1_last_reg || out_free);
    assign text.ready = !s1_valid_reg || s1_fire;
    assign text_take = text.valid && text.ready;

    assign result.valid = out_valid_reg;
    assign result.ok    = out_ok_reg;
    assign result.value = out_value_reg;

    // byte classification and digit accumulate
    assign digit     = rtp_pkg::digit_of(s1_char_reg);
    assign is_sep    = (s1_char_reg == rtp_pkg::CHAR_APOS)
                    || (s1_char_reg == rtp_pkg::CHAR_QUOTE)
                    || (s1_char_reg == rtp_pkg::CHAR_UNDER);
    assign is_space  = s1_char_reg <= rtp_pkg::SPACE_MAX;
    assign digit_hit = digit < {1'b0, radix_reg};
    assign mac       = acc_reg * VALUE_WIDTH'(radix_reg) + VALUE_WIDTH'(digit);
    assign dp_phase  = (is_sep || digit_hit) ? PH_DIGITS
                     : (is_space ? PH_TRAIL : PH_FAIL);

    always_comb
    begin
        upd_phase    = phase_reg;
        upd_negative = negative_reg;
        upd_seen     = seen_reg;
        upd_acc      = acc_reg;
        if (s1_has_reg)
        begin
            unique case (phase_reg)
                PH_LEAD:
                begin
                    if (!is_space)
                    begin
                        if (s1_char_reg == rtp_pkg::CHAR_PLUS)
                        begin
                            upd_phase = PH_DIGITS;
                        end
                        else if (s1_char_reg == rtp_pkg::CHAR_MINUS)
                        begin
                            upd_phase    = PH_DIGITS;
                            upd_negative = 1'b1;
                        end
                        else
                        begin
                            upd_phase = dp_phase;
                            if (digit_hit)
                            begin
                                upd_acc  = mac;
                                upd_seen = 1'b1;
                            end
                        end
                    end
                end
                PH_DIGITS:
                begin
                    upd_phase = dp_phase;
                    if (digit_hit)
                    begin
                        upd_acc  = mac;
                        upd_seen = 1'b1;
                    end
                end
                PH_TRAIL:
                begin
                    if (!is_space)
                    begin
                        upd_phase = PH_FAIL;
                    end
                end
                default:
                begin
                    upd_phase = PH_FAIL;
                end
            endcase
        end
    end

    // result from the updated state
    assign radix_ok = (radix_reg >= rtp_pkg::BASE_MIN) && (radix_reg <= rtp_pkg::BASE_MAX);
    assign good     = upd_seen && (upd_phase != PH_FAIL) && radix_ok;
    assign mag      = upd_negative ? (VALUE_WIDTH'(0) - upd_acc) : upd_acc;
    assign wrapped  = good ? $signed(mag) : '0;

    always_comb
    begin
        phase_next     = phase_reg;
        negative_next  = negative_reg;
        seen_next      = seen_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_value_next = out_value_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                phase_next     = PH_LEAD;
                negative_next  = 1'b0;
                seen_next      = 1'b0;
                acc_next       = '0;
                out_valid_next = 1'b1;
                out_ok_next    = good;
                out_value_next = rtp_pkg::RESULT_W'(wrapped);
            end
            else
            begin
                phase_next    = upd_phase;
                negative_next = upd_negative;
                seen_next     = upd_seen;
                acc_next      = upd_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= rtp_pkg::RADIX_RESET;
            s1_valid_reg  <= 1'b0;
            phase_reg     <= PH_LEAD;
            negative_reg  <= 1'b0;
            seen_reg      <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                radix_reg <= cfg_wdata;
            end
            if (text_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            phase_reg     <= phase_next;
            negative_reg  <= negative_next;
            seen_reg      <= seen_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_take)
        begin
            s1_char_reg <= text.char_byte;
            s1_has_reg  <= text.has_byte;
            s1_last_reg <= text.last;
        end
        out_ok_reg    <= out_ok_next;
        out_value_reg <= out_value_next;
    end

    `RTP_ASSERT_NOW(a_fail_value_zero, clk, rst_n, result.valid && !result.ok,
        result.value == '0, "failed parse carries a nonzero value")

    `RTP_ASSERT_NOW(a_ok_radix_range, clk, rst_n, result.valid && result.ok,
        radix_ok, "ok result with radix out of range")

    `RTP_ASSERT_NEXT(a_last_gives_result, clk, rst_n, s1_fire && s1_last_reg,
        result.valid, "closing request did not produce a result")

    `RTP_ASSERT_NEXT(a_last_clears_state, clk, rst_n, s1_fire && s1_last_reg,
        (phase_reg == PH_LEAD) && !seen_reg && !negative_reg && (acc_reg == '0),
        "parse state not cleared after closing request")

endmodule
